FILE: src/scu_pkg.sv
// Shared types and constants of the sine/cosine unit.
package scu_pkg;

    // Channel payloads
    typedef struct packed {
        logic signed [31:0] angle;
    } t_in_payload;

    typedef struct packed {
        logic signed [31:0] sine;
        logic signed [31:0] cosine;
    } t_out_payload;

    // Quadrant of the folded angle
    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } t_quad;

    // Datapath widths
    localparam int ANGLE_W   = 32;
    localparam int OUT_W     = 32;
    localparam int WORD_W    = 64;
    localparam int HALF_W    = 32;
    localparam int PROD_W    = 128;
    localparam int MAG_W     = 63;
    localparam int WORK_FRAC = 60;
    localparam int TURN_BITS = 40;
    localparam int RQ_W      = TURN_BITS - 2;
    localparam int RAD_W     = 61;
    localparam int SQ_W      = 60;

    // Multiply-round unit latency and polynomial length
    localparam int MUL_LAT      = 5;
    localparam int HORNER_STEPS = 6;

    // 1/(2*pi) as unsigned Q0.64, pi/2 as Q2.61
    localparam logic [WORD_W-1:0]        INV_TWO_PI_Q64 = 64'h28BE60DB9391054A;
    localparam logic signed [WORD_W-1:0] HALF_PI_Q61    = 64'sd3622009729038561421;
    localparam int                       HALF_PI_FRAC   = 61;

    // Horner coefficients, Q60, index 0 is the constant term
    localparam logic signed [WORD_W-1:0] SIN_COEF [0:HORNER_STEPS] = '{
        64'sd1152921504606846976, -64'sd192153584101141163, 64'sd9607679205057058,
        -64'sd228754266787073, 64'sd3177142594265, -64'sd28883114493,
        64'sd185148170
    };
    localparam logic signed [WORD_W-1:0] COS_COEF [0:HORNER_STEPS] = '{
        64'sd1152921504606846976, -64'sd576460752303423488, 64'sd48038396025285291,
        -64'sd1601279867509510, 64'sd28594283348384, -64'sd317714259426,
        64'sd2406926208
    };

endpackage

FILE: src/scu_stream_if.sv
// Valid/ready stream interface carrying one payload per transaction.
interface scu_stream_if #(
    parameter type t_payload = logic
) ();

    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);

endinterface

FILE: src/scu_mul_round.sv
// Five-stage signed multiply, round half away from zero, shift and add constant.
module scu_mul_round #(
    parameter int                                 SH   = 60,
    parameter logic signed [scu_pkg::WORD_W-1:0] COEF = 64'sd0
) (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [scu_pkg::WORD_W-1:0]  i_a,
    input  logic signed [scu_pkg::WORD_W-1:0]  i_b,
    output logic signed [scu_pkg::WORD_W-1:0]  o_value
);

    localparam int WORD_W = scu_pkg::WORD_W;
    localparam int HALF_W = scu_pkg::HALF_W;
    localparam int PROD_W = scu_pkg::PROD_W;
    localparam int MAG_W  = scu_pkg::MAG_W;
    localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(1) << (SH - 1);

    // stage A: sign and magnitudes
    logic              n_neg_a;
    logic [WORD_W-1:0] n_mag_a;
    logic [WORD_W-1:0] n_mag_b;
    logic              r_neg_a;
    logic [WORD_W-1:0] r_mag_a;
    logic [WORD_W-1:0] r_mag_b;

    // stage B: 32x32 partial products
    logic [WORD_W-1:0] n_pp_ll;
    logic [WORD_W-1:0] n_pp_lh;
    logic [WORD_W-1:0] n_pp_hl;
    logic [WORD_W-1:0] n_pp_hh;
    logic [WORD_W-1:0] r_pp_ll;
    logic [WORD_W-1:0] r_pp_lh;
    logic [WORD_W-1:0] r_pp_hl;
    logic [WORD_W-1:0] r_pp_hh;
    logic              r_neg_b;

    // stage C: outer sum with rounding bias, middle sum
    logic [PROD_W-1:0] n_outer;
    logic [WORD_W:0]   n_mid;
    logic [PROD_W-1:0] r_outer;
    logic [WORD_W:0]   r_mid;
    logic              r_neg_c;

    // stage D: full product and shifted magnitude
    logic [PROD_W-1:0] n_total;
    logic [MAG_W-1:0]  n_mag;
    logic [MAG_W-1:0]  r_mag;
    logic              r_neg_d;

    // stage E: signed result plus constant
    logic signed [WORD_W-1:0] n_value;
    logic signed [WORD_W-1:0] r_value;

    always_comb begin
        n_neg_a = i_a[WORD_W-1] ^ i_b[WORD_W-1];
        n_mag_a = i_a[WORD_W-1] ? (WORD_W'(0) - i_a) : i_a;
        n_mag_b = i_b[WORD_W-1] ? (WORD_W'(0) - i_b) : i_b;
    end

    always_comb begin
        n_pp_ll = WORD_W'(r_mag_a[HALF_W-1:0]) * WORD_W'(r_mag_b[HALF_W-1:0]);
        n_pp_lh = WORD_W'(r_mag_a[HALF_W-1:0]) * WORD_W'(r_mag_b[WORD_W-1:HALF_W]);
        n_pp_hl = WORD_W'(r_mag_a[WORD_W-1:HALF_W]) * WORD_W'(r_mag_b[HALF_W-1:0]);
        n_pp_hh = WORD_W'(r_mag_a[WORD_W-1:HALF_W]) * WORD_W'(r_mag_b[WORD_W-1:HALF_W]);
    end

    // high and low products do not overlap, so they concatenate
    always_comb begin
        n_outer = {r_pp_hh, r_pp_ll} + RND_HALF;
        n_mid   = {1'b0, r_pp_lh} + {1'b0, r_pp_hl};
    end

    always_comb begin
        n_total = r_outer + {{(PROD_W - WORD_W - 1 - HALF_W){1'b0}}, r_mid, {HALF_W{1'b0}}};
        n_mag   = n_total[SH +: MAG_W];
    end

    always_comb begin
        if (r_neg_d) begin
            n_value = COEF - WORD_W'(r_mag);
        end else begin
            n_value = COEF + WORD_W'(r_mag);
        end
    end

    // datapath registers, all advance together
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg_a <= n_neg_a;
            r_mag_a <= n_mag_a;
            r_mag_b <= n_mag_b;
            r_pp_ll <= n_pp_ll;
            r_pp_lh <= n_pp_lh;
            r_pp_hl <= n_pp_hl;
            r_pp_hh <= n_pp_hh;
            r_neg_b <= r_neg_a;
            r_outer <= n_outer;
            r_mid   <= n_mid;
            r_neg_c <= r_neg_b;
            r_mag   <= n_mag;
            r_neg_d <= r_neg_c;
            r_value <= n_value;
        end
    end

    assign o_value = r_value;

endmodule

FILE: src/sine_cosine_unit.sv
// Pipelined fixed-point sine and cosine of one angle per transaction.
//
//   Port   | Dir | Handshake   | Payload
//   i_in   | in  | valid/ready | angle, radians, Q8.24
//   o_out  | out | valid/ready | sine, cosine, Q2.30, clamped to +-1.0
//
// One transaction enters per cycle while o_out does not stall.
// The pipe is the chain of nine multiply-round units (five stages each,
// 32x32 partial products), two reduction stages and two output stages.
// Reset clears only the valid bits; payload registers are not reset.
// The whole pipe advances when the output register is empty or being taken;
// while o_out stalls every stage holds and i_in.ready is low.
module sine_cosine_unit #(
    parameter int ANGLE_FRAC_BITS = 24,
    parameter int OUT_FRAC_BITS   = 30
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    scu_stream_if.sink   i_in,
    scu_stream_if.source o_out
);

    localparam int ANGLE_W      = scu_pkg::ANGLE_W;
    localparam int OUT_W        = scu_pkg::OUT_W;
    localparam int WORD_W       = scu_pkg::WORD_W;
    localparam int HALF_W       = scu_pkg::HALF_W;
    localparam int TURN_BITS    = scu_pkg::TURN_BITS;
    localparam int RQ_W         = scu_pkg::RQ_W;
    localparam int RAD_W        = scu_pkg::RAD_W;
    localparam int SQ_W         = scu_pkg::SQ_W;
    localparam int WORK_FRAC    = scu_pkg::WORK_FRAC;
    localparam int MUL_LAT      = scu_pkg::MUL_LAT;
    localparam int HORNER_STEPS = scu_pkg::HORNER_STEPS;

    localparam int TURN_PROD_W = ANGLE_W + WORD_W;
    localparam int TURN_LSB    = WORD_W + ANGLE_FRAC_BITS - TURN_BITS;
    localparam int RAD_SH      = RQ_W + scu_pkg::HALF_PI_FRAC - WORK_FRAC;

    // pipeline positions of the result registers
    localparam int IDX_RQ   = 1;
    localparam int IDX_RAD  = IDX_RQ + MUL_LAT;
    localparam int IDX_SQ   = IDX_RAD + MUL_LAT;
    localparam int IDX_POLY = IDX_SQ + HORNER_STEPS * MUL_LAT;
    localparam int IDX_SIN  = IDX_POLY + MUL_LAT;
    localparam int IDX_SEL  = IDX_SIN + 1;
    localparam int IDX_OUT  = IDX_SEL + 1;

    // delay line lengths
    localparam int QUAD_DLY = IDX_SIN - IDX_RQ;
    localparam int RAD_DLY  = IDX_POLY - IDX_RAD;
    localparam int SQ_DLY   = (HORNER_STEPS - 1) * MUL_LAT;
    localparam int COS_DLY  = IDX_SIN - IDX_POLY;

    // output scaling
    localparam int                       OUT_SH      = WORK_FRAC - OUT_FRAC_BITS;
    localparam logic signed [WORD_W-1:0] OUT_HALF    = 64'sd1 <<< (OUT_SH - 1);
    localparam logic signed [WORD_W-1:0] OUT_ONE     = 64'sd1 <<< OUT_FRAC_BITS;
    localparam logic signed [WORD_W-1:0] OUT_NEG_ONE = -OUT_ONE;
    localparam logic signed [OUT_W-1:0]  OUT_ONE_W   = OUT_W'(OUT_ONE);

    localparam logic signed [HALF_W:0] INV_LO_S =
        {1'b0, scu_pkg::INV_TWO_PI_Q64[HALF_W-1:0]};
    localparam logic signed [HALF_W:0] INV_HI_S =
        {1'b0, scu_pkg::INV_TWO_PI_Q64[WORD_W-1:HALF_W]};

    // round half away from zero to the output format, then clamp to +-1.0
    function automatic logic signed [OUT_W-1:0] to_out(input logic signed [WORD_W-1:0] v);
        logic signed [WORD_W-1:0] biased;
        logic signed [WORD_W-1:0] q;
        biased = v + OUT_HALF - {{(WORD_W - 1){1'b0}}, v[WORD_W-1]};
        q      = biased >>> OUT_SH;
        if (q > OUT_ONE) begin
            q = OUT_ONE;
        end else if (q < OUT_NEG_ONE) begin
            q = OUT_NEG_ONE;
        end
        return q[OUT_W-1:0];
    endfunction

    logic adv;
    logic [0:IDX_OUT] r_valid;

    // reduction registers
    logic signed [ANGLE_W+HALF_W:0] prod_lo;
    logic signed [ANGLE_W+HALF_W:0] prod_hi;
    logic signed [WORD_W-1:0]       r_pp_lo;
    logic signed [WORD_W-1:0]       r_pp_hi;
    logic signed [TURN_PROD_W-1:0]  turn_prod;
    logic [TURN_BITS-1:0]           turn_frac;
    logic [2:0]                     turn_top;
    scu_pkg::t_quad                 n_quad;
    logic signed [RQ_W-1:0]         n_rq;
    scu_pkg::t_quad                 r_quad;
    logic signed [RQ_W-1:0]         r_rq;

    // multiply chain
    logic signed [WORD_W-1:0] rem_rad;
    logic signed [WORD_W-1:0] rem_sq;
    logic signed [WORD_W-1:0] sq_tap   [1:HORNER_STEPS];
    logic signed [WORD_W-1:0] sin_poly [0:HORNER_STEPS];
    logic signed [WORD_W-1:0] cos_poly [0:HORNER_STEPS];
    logic signed [WORD_W-1:0] sin_val;

    // delay lines
    scu_pkg::t_quad          r_quad_dly [0:QUAD_DLY-1];
    logic signed [RAD_W-1:0] r_rad_dly  [0:RAD_DLY-1];
    logic [SQ_W-1:0]         r_sq_dly   [0:SQ_DLY-1];
    logic signed [WORD_W-1:0] r_cos_dly [0:COS_DLY-1];

    // quadrant select and output
    logic signed [WORD_W-1:0] n_sel_sin;
    logic signed [WORD_W-1:0] n_sel_cos;
    logic signed [WORD_W-1:0] r_sel_sin;
    logic signed [WORD_W-1:0] r_sel_cos;
    scu_pkg::t_out_payload    n_out;
    scu_pkg::t_out_payload    r_out;

    // global advance: output register empty or being taken
    assign adv        = o_out.ready || !r_valid[IDX_OUT];
    assign i_in.ready = adv;

    // valid bits travel alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (adv) begin
            r_valid <= {i_in.valid, r_valid[0:IDX_OUT-1]};
        end
    end

    // angle times 1/(2*pi), split into two 32x32 products
    assign prod_lo = i_in.payload.angle * INV_LO_S;
    assign prod_hi = i_in.payload.angle * INV_HI_S;

    // sum to turns, fold, split into quadrant and remainder in quarter turns
    always_comb begin
        turn_prod = {r_pp_hi, {HALF_W{1'b0}}} + {{HALF_W{r_pp_lo[WORD_W-1]}}, r_pp_lo};
        turn_frac = turn_prod[TURN_LSB +: TURN_BITS];
        turn_top  = turn_frac[TURN_BITS-1 -: 3] + 3'd1;
        n_quad    = scu_pkg::t_quad'(turn_top[2:1]);
        n_rq      = {~turn_top[0], turn_frac[RQ_W-2:0]};
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pp_lo <= prod_lo[WORD_W-1:0];
            r_pp_hi <= prod_hi[WORD_W-1:0];
            r_quad  <= n_quad;
            r_rq    <= n_rq;
        end
    end

    // r = remainder * pi/2
    scu_mul_round #(
        .SH   (RAD_SH),
        .COEF (64'sd0)
    ) u_rad (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_a     (WORD_W'(r_rq)),
        .i_b     (scu_pkg::HALF_PI_Q61),
        .o_value (rem_rad)
    );

    // r squared
    scu_mul_round #(
        .SH   (WORK_FRAC),
        .COEF (64'sd0)
    ) u_sq (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_a     (rem_rad),
        .i_b     (rem_rad),
        .o_value (rem_sq)
    );

    assign sin_poly[0] = scu_pkg::SIN_COEF[HORNER_STEPS];
    assign cos_poly[0] = scu_pkg::COS_COEF[HORNER_STEPS];

    // Horner steps in r squared, sine and cosine side by side
    for (genvar j = 1; j <= HORNER_STEPS; j++) begin : g_horner
        if (j == 1) begin : g_first
            assign sq_tap[j] = {{(WORD_W - SQ_W){1'b0}}, rem_sq[SQ_W-1:0]};
        end else begin : g_tap
            assign sq_tap[j] = {{(WORD_W - SQ_W){1'b0}}, r_sq_dly[(j-1)*MUL_LAT-1]};
        end

        scu_mul_round #(
            .SH   (WORK_FRAC),
            .COEF (scu_pkg::SIN_COEF[HORNER_STEPS-j])
        ) u_sin_step (
            .i_clk   (i_clk),
            .i_en    (adv),
            .i_a     (sq_tap[j]),
            .i_b     (sin_poly[j-1]),
            .o_value (sin_poly[j])
        );

        scu_mul_round #(
            .SH   (WORK_FRAC),
            .COEF (scu_pkg::COS_COEF[HORNER_STEPS-j])
        ) u_cos_step (
            .i_clk   (i_clk),
            .i_en    (adv),
            .i_a     (sq_tap[j]),
            .i_b     (cos_poly[j-1]),
            .o_value (cos_poly[j])
        );
    end

    // sin(r) = r * polynomial
    scu_mul_round #(
        .SH   (WORK_FRAC),
        .COEF (64'sd0)
    ) u_sin (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_a     (WORD_W'(r_rad_dly[RAD_DLY-1])),
        .i_b     (sin_poly[HORNER_STEPS]),
        .o_value (sin_val)
    );

    // delay lines for quadrant, r, r squared and cosine
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_quad_dly[0] <= r_quad;
            for (int i = 1; i < QUAD_DLY; i++) begin
                r_quad_dly[i] <= r_quad_dly[i-1];
            end
            r_rad_dly[0] <= rem_rad[RAD_W-1:0];
            for (int i = 1; i < RAD_DLY; i++) begin
                r_rad_dly[i] <= r_rad_dly[i-1];
            end
            r_sq_dly[0] <= rem_sq[SQ_W-1:0];
            for (int i = 1; i < SQ_DLY; i++) begin
                r_sq_dly[i] <= r_sq_dly[i-1];
            end
            r_cos_dly[0] <= cos_poly[HORNER_STEPS];
            for (int i = 1; i < COS_DLY; i++) begin
                r_cos_dly[i] <= r_cos_dly[i-1];
            end
        end
    end

    // quadrant selects and negates
    always_comb begin
        case (r_quad_dly[QUAD_DLY-1])
            scu_pkg::QUAD_0: begin
                n_sel_sin = sin_val;
                n_sel_cos = r_cos_dly[COS_DLY-1];
            end
            scu_pkg::QUAD_1: begin
                n_sel_sin = r_cos_dly[COS_DLY-1];
                n_sel_cos = -sin_val;
            end
            scu_pkg::QUAD_2: begin
                n_sel_sin = -sin_val;
                n_sel_cos = -r_cos_dly[COS_DLY-1];
            end
            scu_pkg::QUAD_3: begin
                n_sel_sin = -r_cos_dly[COS_DLY-1];
                n_sel_cos = sin_val;
            end
            default: begin
                n_sel_sin = '0;
                n_sel_cos = '0;
            end
        endcase
    end

    // round and clamp into the output register
    always_comb begin
        n_out.sine   = to_out(r_sel_sin);
        n_out.cosine = to_out(r_sel_cos);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sel_sin <= n_sel_sin;
            r_sel_cos <= n_sel_cos;
            r_out     <= n_out;
        end
    end

    assign o_out.valid   = r_valid[IDX_OUT];
    assign o_out.payload = r_out;

`ifndef SYNTH
    a_rad_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[IDX_RAD] |->
            rem_rad[WORD_W-1:RAD_W-1] == {(WORD_W - RAD_W + 1){rem_rad[WORD_W-1]}})
        else $error("r exceeds its delay line width");

    a_sq_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[IDX_SQ] |-> rem_sq[WORD_W-1:SQ_W] == '0)
        else $error("r squared negative or too wide");

    a_out_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |->
            (o_out.payload.sine <= OUT_ONE_W && o_out.payload.sine >= -OUT_ONE_W &&
             o_out.payload.cosine <= OUT_ONE_W && o_out.payload.cosine >= -OUT_ONE_W))
        else $error("result outside +-1.0");
`endif

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench of the sine/cosine unit with a scoreboard class.
`timescale 1ns / 100ps

module tb;

    // Fixed-point formats of the unit
    localparam int ANGLE_FRAC  = 24;
    localparam int OUT_FRAC    = 30;
    localparam int FRAC60      = 60;
    localparam int TURN_W      = 40;
    localparam int TURN_LSB    = 64 + ANGLE_FRAC - TURN_W;
    localparam int RQ_SHIFT    = (TURN_W - 2) + 61 - FRAC60;

    // 1/(2*pi) as unsigned Q0.64, pi/2 as Q2.61
    localparam logic [63:0]        RECIP_TWO_PI = 64'h28BE60DB9391054A;
    localparam logic signed [63:0] QUARTER_TURN = 64'sd3622009729038561421;

    // Taylor terms in Q60, constant term first
    localparam logic signed [63:0] SINE_TAYLOR [0:6] = '{
        64'sd1152921504606846976, -64'sd192153584101141163, 64'sd9607679205057058,
        -64'sd228754266787073, 64'sd3177142594265, -64'sd28883114493,
        64'sd185148170
    };
    localparam logic signed [63:0] COSINE_TAYLOR [0:6] = '{
        64'sd1152921504606846976, -64'sd576460752303423488, 64'sd48038396025285291,
        -64'sd1601279867509510, 64'sd28594283348384, -64'sd317714259426,
        64'sd2406926208
    };

    // Angles in Q8.24
    localparam int PI_Q24      = 52707179;
    localparam int HALF_PI_Q24 = 26353589;
    localparam int QTR_PI_Q24  = 13176795;

    localparam int RANDOM_ANGLES = 1150;
    localparam int PIPE_DRAIN    = 60;
    localparam int LONG_HOLD     = 300;
    localparam int CYCLE_LIMIT   = 200000;

    // Predicts sine/cosine pairs and checks them in order
    class sincos_scoreboard;
        scu_pkg::t_out_payload expected_pairs[$];
        int unsigned           error_count;

        function new();
            error_count = 0;
        endfunction

        // round(a*b / 2^sh), ties away from zero, magnitude kept to 63 bits
        function logic signed [63:0] mul_round(logic signed [63:0] a,
                                               logic signed [63:0] b, int sh);
            logic         neg;
            logic [63:0]  ua;
            logic [63:0]  ub;
            logic [127:0] prod;
            logic [62:0]  mag;
            neg  = a[63] ^ b[63];
            ua   = a[63] ? (64'd0 - a) : a;
            ub   = b[63] ? (64'd0 - b) : b;
            prod = {64'd0, ua} * {64'd0, ub};
            prod = prod + (128'd1 << (sh - 1));
            mag  = 63'(prod >> sh);
            return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        endfunction

        function logic signed [63:0] taylor_sum(logic is_sine, logic signed [63:0] r2);
            logic signed [63:0] acc;
            acc = is_sine ? SINE_TAYLOR[6] : COSINE_TAYLOR[6];
            for (int i = 5; i >= 0; i--) begin
                acc = (is_sine ? SINE_TAYLOR[i] : COSINE_TAYLOR[i]) +
                      mul_round(r2, acc, FRAC60);
            end
            return acc;
        endfunction

        // Scale Q60 to the output format and clamp to +-1.0
        function logic signed [31:0] to_output(logic signed [63:0] v);
            logic signed [63:0] o;
            o = mul_round(v, 64'sd1, FRAC60 - OUT_FRAC);
            if (o > (64'sd1 <<< OUT_FRAC))
                o = 64'sd1 <<< OUT_FRAC;
            if (o < -(64'sd1 <<< OUT_FRAC))
                o = -(64'sd1 <<< OUT_FRAC);
            return o[31:0];
        endfunction

        function scu_pkg::t_out_payload predict_sincos(logic signed [31:0] angle);
            logic signed [127:0]   turns;
            logic [TURN_W-1:0]     frac_turn;
            logic [TURN_W:0]       nearest;
            scu_pkg::t_quad        quad;
            logic signed [63:0]    rem_q;
            logic signed [63:0]    r;
            logic signed [63:0]    r2;
            logic signed [63:0]    s;
            logic signed [63:0]    c;
            logic signed [63:0]    so;
            logic signed [63:0]    co;
            scu_pkg::t_out_payload res;
            // Angle times 1/(2*pi), fractional turn only
            turns     = $signed({{96{angle[31]}}, angle}) * $signed({64'd0, RECIP_TWO_PI});
            frac_turn = turns[TURN_LSB +: TURN_W];
            nearest   = ({1'b0, frac_turn} + ((TURN_W + 1)'(1) << (TURN_W - 3))) >> (TURN_W - 2);
            quad      = scu_pkg::t_quad'(nearest[1:0]);
            rem_q     = $signed(64'(frac_turn)) - $signed(64'(nearest) << (TURN_W - 2));
            r         = mul_round(rem_q, QUARTER_TURN, RQ_SHIFT);
            r2        = mul_round(r, r, FRAC60);
            s         = mul_round(r, taylor_sum(1'b1, r2), FRAC60);
            c         = taylor_sum(1'b0, r2);
            case (quad)
                scu_pkg::QUAD_0: begin so = s;  co = c;  end
                scu_pkg::QUAD_1: begin so = c;  co = -s; end
                scu_pkg::QUAD_2: begin so = -s; co = -c; end
                default: begin so = -c; co = s; end
            endcase
            res.sine   = to_output(so);
            res.cosine = to_output(co);
            return res;
        endfunction

        function void note_angle(logic signed [31:0] angle);
            expected_pairs.push_back(predict_sincos(angle));
        endfunction

        function void check_result(scu_pkg::t_out_payload got);
            scu_pkg::t_out_payload want;
            if (expected_pairs.size() == 0) begin
                $display("%0t unexpected result: sine %0d cosine %0d", $time,
                         got.sine, got.cosine);
                error_count++;
                return;
            end
            want = expected_pairs.pop_front();
            if (got.sine !== want.sine) begin
                $display("%0t sine mismatch: expected %0d, actual %0d", $time,
                         want.sine, got.sine);
                error_count++;
            end
            if (got.cosine !== want.cosine) begin
                $display("%0t cosine mismatch: expected %0d, actual %0d", $time,
                         want.cosine, got.cosine);
                error_count++;
            end
        endfunction

        function int pending();
            return expected_pairs.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    scu_stream_if #(.t_payload(scu_pkg::t_in_payload))  in_if ();
    scu_stream_if #(.t_payload(scu_pkg::t_out_payload)) out_if ();

    sine_cosine_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    sincos_scoreboard sb;
    int unsigned      cycle_count = 0;
    logic             sender_burst = 1'b0;
    logic             hold_output  = 1'b0;
    logic             reset_done   = 1'b0;

    // Clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // Transaction monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready)
                sb.note_angle(in_if.payload.angle);
            if (out_if.valid && out_if.ready)
                sb.check_result(out_if.payload);
        end
    end

    // Offer one angle, after a random gap unless in a burst
    task automatic send_angle(input logic signed [31:0] angle);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.payload.angle <= angle;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    function automatic logic signed [31:0] random_angle();
        int k;
        case ($urandom_range(0, 3))
            0, 1: return $urandom;
            // within a few turns of zero
            2: return int'($urandom_range(0, 16 * PI_Q24)) - 8 * PI_Q24;
            // close to a multiple of pi/4; at its odd multiples the quadrant flips
            default: begin
                k = int'($urandom_range(0, 324)) - 162;
                return k * QTR_PI_Q24 + int'($urandom_range(0, 32)) - 16;
            end
        endcase
    endfunction

    // Output side: random stalls, bursts and one long hold-off
    initial begin
        int stall;
        int burst_left;
        out_if.ready <= 1'b0;
        burst_left = 0;
        wait (reset_done);
        forever begin
            if (hold_output) begin
                hold_output = 1'b0;
                out_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                if (burst_left > 0)
                    burst_left--;
                else if ($urandom_range(0, 31) == 0)
                    burst_left = $urandom_range(20, 80);
                stall = (burst_left > 0) ? 0 : $urandom_range(0, 7);
                if (stall != 0) begin
                    out_if.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
        end
    end

    // Reset, directed angles, random angles, drain
    initial begin
        logic signed [31:0] directed [] = '{
            32'sd0, 32'sd1, -32'sd1, 32'sh7FFFFFFF, 32'sh80000000,
            QTR_PI_Q24, -QTR_PI_Q24, QTR_PI_Q24 - 1, QTR_PI_Q24 + 1,
            HALF_PI_Q24, -HALF_PI_Q24, PI_Q24, -PI_Q24,
            3 * HALF_PI_Q24, 4 * HALF_PI_Q24, 4 * HALF_PI_Q24 - 1,
            3 * QTR_PI_Q24, 32'sh00000100, 32'sh40000000, 32'shC0000000,
            32'sh55555555, 32'shAAAAAAAA, 32'sh00FFFFFF
        };
        int hold_at;
        sb = new();
        i_rst_n             <= 1'b0;
        in_if.valid         <= 1'b0;
        in_if.payload.angle <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n    <= 1'b1;
        reset_done = 1'b1;
        @(posedge i_clk);

        foreach (directed[i])
            send_angle(directed[i]);

        hold_at = $urandom_range(200, 600);
        for (int n = 0; n < RANDOM_ANGLES; n++) begin
            if (n % 40 == 0)
                sender_burst = ($urandom_range(0, 3) == 0);
            // from here the sender keeps offering while the output is held
            if (n == hold_at) begin
                sender_burst = 1'b1;
                hold_output  = 1'b1;
            end
            send_angle(random_angle());
        end
        in_if.valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (PIPE_DRAIN) @(posedge i_clk);
        if (sb.error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
